FILE: hdl/frjs_pkg.sv
// Types and constants shared by the job scheduler files.
package frjs_pkg;

   localparam int STATUS_W = 2;
   localparam int CNT_W    = 32;
   localparam int SUM_W    = 40;
   localparam int FIELD_UNITS_W = 7;
   localparam int FIELD_DUR_W   = 16;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_UNITS  = 2'd2;

   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_WALK     = 7'b0000010,
      ST_HEAD_RD  = 7'b0000100,
      ST_HEAD_CHK = 7'b0001000,
      ST_SCAN     = 7'b0010000,
      ST_FINISH   = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

endpackage

FILE: hdl/frjs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/fifo_resource_job_scheduler.sv
// Top level of the head-of-line FIFO job scheduler with its sequencer.
// Arrival: accepted in idle, then its result is loaded in the done state once the output register is free.
// Tick: walks the slot RAM one slot per cycle to age the running jobs, then for each queue
//   head reads it (HEAD_RD), checks it against the free units (HEAD_CHK) and scans the slot
//   table for a free slot (SCAN); then FINISH adds to the busy sum and DONE loads the result.
// One transaction at a time; synchronous reset clears queue, slot table and counters.
module fifo_resource_job_scheduler #(
   parameter int QUEUE_DEPTH   = 64,
   parameter int MAX_UNITS     = 64,
   parameter int DURATION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [15:0] req_job_duration,
   input  logic [6:0]  req_job_units,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_arrived_total,
   output logic [31:0] rsp_started_total,
   output logic [31:0] rsp_completed_total,
   output logic [6:0]  rsp_busy_units,
   output logic [39:0] rsp_busy_sum,
   output logic [6:0]  rsp_pending_count,

   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data
);

   localparam int UB  = $clog2(MAX_UNITS + 1);
   localparam int CW  = (UB > frjs_pkg::FIELD_UNITS_W) ? UB : frjs_pkg::FIELD_UNITS_W;
   localparam int SW  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
   localparam int SPW = $clog2(MAX_UNITS + 1);
   localparam int QW  = $clog2(QUEUE_DEPTH);
   localparam int FW  = $clog2(QUEUE_DEPTH + 1);
   localparam int DB  = DURATION_BITS;
   localparam int WW  = UB + DB;
   localparam int TOTAL_RESET = (MAX_UNITS < 64) ? MAX_UNITS : 64;
   localparam int CNT_W = frjs_pkg::CNT_W;
   localparam int SUM_W = frjs_pkg::SUM_W;

   frjs_pkg::state_type state_ff, state_in;

   logic [UB-1:0]        total_ff, total_in;
   logic [UB-1:0]        busy_units_ff, busy_units_in;
   logic [UB-1:0]        free_units;
   logic [MAX_UNITS-1:0] slot_busy_ff, slot_busy_in;

   logic [QW-1:0]        head_ff, head_in;
   logic [QW-1:0]        tail_ff, tail_in;
   logic [FW-1:0]        fill_ff, fill_in;

   logic [CNT_W-1:0]     arrivals_ff, arrivals_in;
   logic [CNT_W-1:0]     starts_ff, starts_in;
   logic [CNT_W-1:0]     finishes_ff, finishes_in;
   logic [SUM_W-1:0]     load_acc_ff, load_acc_in;
   logic [SUM_W:0]       load_sum;

   logic [SPW-1:0]       walk_ptr_ff, walk_ptr_in;
   logic                 walk_vld_ff, walk_vld_in;
   logic [SW-1:0]        walk_idx_ff, walk_idx_in;
   logic [SPW-1:0]       scan_ptr_ff, scan_ptr_in;

   logic [frjs_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [UB-1:0]        head_need_ff, head_need_in;
   logic [DB-1:0]        head_dur_ff, head_dur_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;
   logic [1:0]           rsp_status_ff;
   logic [31:0]          rsp_arrived_ff, rsp_started_ff, rsp_completed_ff;
   logic [6:0]           rsp_busy_units_ff, rsp_pending_ff;
   logic [39:0]          rsp_busy_sum_ff;

   logic                 q_wr_en, q_rd_en;
   logic [WW-1:0]        q_wr_data, q_rd_data;
   logic                 s_wr_en, s_rd_en;
   logic [SW-1:0]        s_wr_addr, s_rd_addr;
   logic [WW-1:0]        s_wr_data, s_rd_data;

   logic                 req_accept;
   logic                 units_bad;
   logic [UB-1:0]        walk_need;
   logic [DB-1:0]        walk_rem;

   frjs_ram #(.WIDTH(WW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (tail_ff),
      .wr_data (q_wr_data),
      .rd_en   (q_rd_en),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   frjs_ram #(.WIDTH(WW), .DEPTH(MAX_UNITS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   assign req_stall  = (state_ff != frjs_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign free_units = (total_ff > busy_units_ff) ? UB'(total_ff - busy_units_ff) : '0;
   assign units_bad  = (req_job_units == '0) || (CW'(req_job_units) > CW'(total_ff));
   assign walk_need  = s_rd_data[WW-1:DB];
   assign walk_rem   = s_rd_data[DB-1:0];
   assign load_sum   = {1'b0, load_acc_ff} + (SUM_W+1)'(busy_units_ff);
   assign rsp_load   = (state_ff == frjs_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign q_wr_data  = {UB'(req_job_units), DB'(req_job_duration)};

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      busy_units_in = busy_units_ff;
      slot_busy_in  = slot_busy_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      arrivals_in   = arrivals_ff;
      starts_in     = starts_ff;
      finishes_in   = finishes_ff;
      load_acc_in   = load_acc_ff;
      walk_ptr_in   = walk_ptr_ff;
      walk_vld_in   = 1'b0;
      walk_idx_in   = walk_idx_ff;
      scan_ptr_in   = scan_ptr_ff;
      status_in     = status_ff;
      head_need_in  = head_need_ff;
      head_dur_in   = head_dur_ff;
      q_wr_en       = 1'b0;
      q_rd_en       = 1'b0;
      s_wr_en       = 1'b0;
      s_wr_addr     = walk_idx_ff;
      s_wr_data     = '0;
      s_rd_en       = 1'b0;
      s_rd_addr     = walk_ptr_ff[SW-1:0];

      if (csr_write_enable) begin
         total_in = (int'(csr_write_data) > MAX_UNITS) ? UB'(MAX_UNITS) : UB'(csr_write_data);
      end

      case (state_ff)
         frjs_pkg::ST_IDLE: begin
            if (req_accept) begin
               status_in = frjs_pkg::STATUS_OK;
               if (req_kind == frjs_pkg::KIND_TICK) begin
                  walk_ptr_in = '0;
                  state_in    = frjs_pkg::ST_WALK;
               end else begin
                  if (units_bad) begin
                     status_in = frjs_pkg::STATUS_BAD_UNITS;
                  end else if (fill_ff == FW'(QUEUE_DEPTH)) begin
                     status_in = frjs_pkg::STATUS_QUEUE_FULL;
                  end else begin
                     q_wr_en     = 1'b1;
                     tail_in     = (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(tail_ff + 1'b1);
                     fill_in     = FW'(fill_ff + 1'b1);
                     arrivals_in = (arrivals_ff == '1) ? arrivals_ff : arrivals_ff + 1'b1;
                  end
                  state_in = frjs_pkg::ST_DONE;
               end
            end
         end
         frjs_pkg::ST_WALK: begin
            if (walk_ptr_ff < SPW'(MAX_UNITS)) begin
               s_rd_en     = 1'b1;
               walk_vld_in = 1'b1;
               walk_idx_in = walk_ptr_ff[SW-1:0];
               walk_ptr_in = SPW'(walk_ptr_ff + 1'b1);
            end else begin
               scan_ptr_in = '0;
               state_in    = frjs_pkg::ST_HEAD_RD;
            end
            if (walk_vld_ff && slot_busy_ff[walk_idx_ff]) begin
               if (walk_rem[DB-1:1] == '0) begin
                  slot_busy_in[walk_idx_ff] = 1'b0;
                  busy_units_in = UB'(busy_units_ff - walk_need);
                  finishes_in = (finishes_ff == '1) ? finishes_ff : finishes_ff + 1'b1;
               end else begin
                  s_wr_en   = 1'b1;
                  s_wr_data = {walk_need, DB'(walk_rem - 1'b1)};
               end
            end
         end
         frjs_pkg::ST_HEAD_RD: begin
            if (fill_ff == '0) begin
               state_in = frjs_pkg::ST_FINISH;
            end else begin
               q_rd_en  = 1'b1;
               state_in = frjs_pkg::ST_HEAD_CHK;
            end
         end
         frjs_pkg::ST_HEAD_CHK: begin
            head_need_in = q_rd_data[WW-1:DB];
            head_dur_in  = q_rd_data[DB-1:0];
            if (q_rd_data[WW-1:DB] > free_units) begin
               state_in = frjs_pkg::ST_FINISH;
            end else begin
               state_in = frjs_pkg::ST_SCAN;
            end
         end
         frjs_pkg::ST_SCAN: begin
            if (scan_ptr_ff >= SPW'(MAX_UNITS)) begin
               state_in = frjs_pkg::ST_FINISH;
            end else if (!slot_busy_ff[scan_ptr_ff[SW-1:0]]) begin
               s_wr_en       = 1'b1;
               s_wr_addr     = scan_ptr_ff[SW-1:0];
               s_wr_data     = {head_need_ff, head_dur_ff};
               slot_busy_in[scan_ptr_ff[SW-1:0]] = 1'b1;
               busy_units_in = UB'(busy_units_ff + head_need_ff);
               head_in       = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(head_ff + 1'b1);
               fill_in       = FW'(fill_ff - 1'b1);
               starts_in     = (starts_ff == '1) ? starts_ff : starts_ff + 1'b1;
               scan_ptr_in   = SPW'(scan_ptr_ff + 1'b1);
               state_in      = frjs_pkg::ST_HEAD_RD;
            end else begin
               scan_ptr_in = SPW'(scan_ptr_ff + 1'b1);
            end
         end
         frjs_pkg::ST_FINISH: begin
            load_acc_in = load_sum[SUM_W] ? '1 : load_sum[SUM_W-1:0];
            state_in    = frjs_pkg::ST_DONE;
         end
         frjs_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = frjs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frjs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= frjs_pkg::ST_IDLE;
         total_ff      <= UB'(TOTAL_RESET);
         busy_units_ff <= '0;
         slot_busy_ff  <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         arrivals_ff   <= '0;
         starts_ff     <= '0;
         finishes_ff   <= '0;
         load_acc_ff   <= '0;
         walk_ptr_ff   <= '0;
         walk_vld_ff   <= 1'b0;
         scan_ptr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         busy_units_ff <= busy_units_in;
         slot_busy_ff  <= slot_busy_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         arrivals_ff   <= arrivals_in;
         starts_ff     <= starts_in;
         finishes_ff   <= finishes_in;
         load_acc_ff   <= load_acc_in;
         walk_ptr_ff   <= walk_ptr_in;
         walk_vld_ff   <= walk_vld_in;
         scan_ptr_ff   <= scan_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff  <= walk_idx_in;
      status_ff    <= status_in;
      head_need_ff <= head_need_in;
      head_dur_ff  <= head_dur_in;
      if (rsp_load) begin
         rsp_status_ff     <= status_ff;
         rsp_arrived_ff    <= arrivals_ff;
         rsp_started_ff    <= starts_ff;
         rsp_completed_ff  <= finishes_ff;
         rsp_busy_units_ff <= 7'(busy_units_ff);
         rsp_busy_sum_ff   <= load_acc_ff;
         rsp_pending_ff    <= 7'(fill_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_arrived_total   = rsp_arrived_ff;
   assign rsp_started_total   = rsp_started_ff;
   assign rsp_completed_total = rsp_completed_ff;
   assign rsp_busy_units      = rsp_busy_units_ff;
   assign rsp_busy_sum        = rsp_busy_sum_ff;
   assign rsp_pending_count   = rsp_pending_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != frjs_pkg::ST_IDLE))
      else $error("accepted transaction did not start the sequencer");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

   a_busy_bound: assert property (@(posedge clock) disable iff (reset)
      busy_units_ff <= UB'(MAX_UNITS))
      else $error("busy units above cluster maximum");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == frjs_pkg::ST_IDLE))
      else $error("result not presented after completion");

   a_no_start_when_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == frjs_pkg::ST_HEAD_CHK) |-> (fill_ff != '0))
      else $error("queue head checked while queue empty");

endmodule

FILE: bench/fifo_resource_job_scheduler_test.sv
// Self-checking bench for the FIFO head-of-line job scheduler.
`timescale 1ns / 100ps

module fifo_resource_job_scheduler_test;

   localparam int STATUS_W      = frjs_pkg::STATUS_W;
   localparam int CNT_W         = frjs_pkg::CNT_W;
   localparam int SUM_W         = frjs_pkg::SUM_W;
   localparam int FIELD_UNITS_W = frjs_pkg::FIELD_UNITS_W;
   localparam int FIELD_DUR_W   = frjs_pkg::FIELD_DUR_W;

   localparam int JOB_QUEUE_DEPTH = 64;
   localparam int SLOT_COUNT      = 64;
   localparam logic [SUM_W-1:0] BUSY_SUM_CEILING = {SUM_W{1'b1}};
   localparam logic [CNT_W-1:0] COUNT_CEILING    = {CNT_W{1'b1}};

   typedef struct {
      logic                     kind;
      logic [FIELD_DUR_W-1:0]   duration;
      logic [FIELD_UNITS_W-1:0] units;
   } job_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [CNT_W-1:0]         arrived;
      logic [CNT_W-1:0]         started;
      logic [CNT_W-1:0]         completed;
      logic [FIELD_UNITS_W-1:0] busy;
      logic [SUM_W-1:0]         busy_sum;
      logic [FIELD_UNITS_W-1:0] pending;
   } sched_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_kind = frjs_pkg::KIND_TICK;
   logic [FIELD_DUR_W-1:0]   req_job_duration = '0;
   logic [FIELD_UNITS_W-1:0] req_job_units = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [CNT_W-1:0]         rsp_arrived_total;
   logic [CNT_W-1:0]         rsp_started_total;
   logic [CNT_W-1:0]         rsp_completed_total;
   logic [FIELD_UNITS_W-1:0] rsp_busy_units;
   logic [SUM_W-1:0]         rsp_busy_sum;
   logic [FIELD_UNITS_W-1:0] rsp_pending_count;

   logic                     csr_write_enable = 1'b0;
   logic [FIELD_UNITS_W-1:0] csr_write_data = '0;

   fifo_resource_job_scheduler #(
      .QUEUE_DEPTH   (JOB_QUEUE_DEPTH),
      .MAX_UNITS     (SLOT_COUNT),
      .DURATION_BITS (FIELD_DUR_W)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_job_duration    (req_job_duration),
      .req_job_units       (req_job_units),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_arrived_total   (rsp_arrived_total),
      .rsp_started_total   (rsp_started_total),
      .rsp_completed_total (rsp_completed_total),
      .rsp_busy_units      (rsp_busy_units),
      .rsp_busy_sum        (rsp_busy_sum),
      .rsp_pending_count   (rsp_pending_count),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   // scheduler state mirror
   logic [FIELD_DUR_W-1:0]   wait_duration [JOB_QUEUE_DEPTH];
   logic [FIELD_UNITS_W-1:0] wait_need     [JOB_QUEUE_DEPTH];
   int unsigned              wait_head, wait_tail, wait_fill;
   logic [FIELD_DUR_W-1:0]   run_left [SLOT_COUNT];
   logic [FIELD_UNITS_W-1:0] run_need [SLOT_COUNT];
   bit                       run_on   [SLOT_COUNT];
   int unsigned              units_cfg;
   logic [CNT_W-1:0]         arrivals, starts, finishes;
   logic [SUM_W-1:0]         load_sum;

   job_item_type     offered_jobs[$];
   sched_report_type predicted_reports[$];
   job_item_type     on_offer;
   int               send_gap = 0;
   int               stall_left = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;
   bit               idling_on = 1'b1;
   int               results_seen = 0;
   int               error_count = 0;

   function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] v);
      return (v == COUNT_CEILING) ? v : v + 1'b1;
   endfunction

   function automatic int unsigned units_in_use();
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < SLOT_COUNT; i++)
         if (run_on[i]) sum += run_need[i];
      return sum;
   endfunction

   function automatic sched_report_type schedule_step(job_item_type it);
      sched_report_type r;
      int               slot;
      int unsigned      busy, free_u;
      logic [SUM_W:0]   grown;
      r.status = frjs_pkg::STATUS_OK;
      if (it.kind == frjs_pkg::KIND_ARRIVAL) begin
         if (it.units == 0 || it.units > units_cfg) begin
            r.status = frjs_pkg::STATUS_BAD_UNITS;
         end else if (wait_fill >= JOB_QUEUE_DEPTH) begin
            r.status = frjs_pkg::STATUS_QUEUE_FULL;
         end else begin
            wait_duration[wait_tail] = it.duration;
            wait_need[wait_tail] = it.units;
            wait_tail = (wait_tail + 1) % JOB_QUEUE_DEPTH;
            wait_fill++;
            arrivals = sat_count(arrivals);
         end
      end else begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (run_on[i]) begin
               if (run_left[i] <= 1) begin
                  run_on[i] = 1'b0;
                  finishes = sat_count(finishes);
               end else begin
                  run_left[i] = run_left[i] - 1'b1;
               end
            end
         end
         while (wait_fill > 0) begin
            busy = units_in_use();
            free_u = (units_cfg > busy) ? units_cfg - busy : 0;
            if (wait_need[wait_head] > free_u) break;
            slot = -1;
            for (int s = SLOT_COUNT - 1; s >= 0; s--)
               if (!run_on[s]) slot = s;
            if (slot < 0) break;
            run_on[slot] = 1'b1;
            run_need[slot] = wait_need[wait_head];
            run_left[slot] = wait_duration[wait_head];
            wait_head = (wait_head + 1) % JOB_QUEUE_DEPTH;
            wait_fill--;
            starts = sat_count(starts);
         end
         grown = {1'b0, load_sum} + (SUM_W+1)'(units_in_use());
         load_sum = (grown > BUSY_SUM_CEILING) ? BUSY_SUM_CEILING : grown[SUM_W-1:0];
      end
      r.arrived   = arrivals;
      r.started   = starts;
      r.completed = finishes;
      r.busy      = FIELD_UNITS_W'(units_in_use());
      r.busy_sum  = load_sum;
      r.pending   = FIELD_UNITS_W'(wait_fill);
      return r;
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      if (!idling_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic job_item_type random_job();
      job_item_type it;
      int unsigned  r, cap;
      it.kind = ($urandom_range(0, 99) < 45) ? frjs_pkg::KIND_ARRIVAL : frjs_pkg::KIND_TICK;
      it.duration = FIELD_DUR_W'($urandom);
      it.units = FIELD_UNITS_W'($urandom);
      if (it.kind == frjs_pkg::KIND_ARRIVAL) begin
         cap = (units_cfg == 0) ? 1 : units_cfg;
         r = $urandom_range(0, 99);
         if (r < 4) it.units = '0;
         else if (r < 8) it.units = FIELD_UNITS_W'($urandom_range(SLOT_COUNT + 1, 127));
         else if (r < 11) it.units = FIELD_UNITS_W'(cap + 1);
         else if (r < 18) it.units = FIELD_UNITS_W'(cap);
         else if (r < 70) it.units = FIELD_UNITS_W'($urandom_range(1, (cap > 8) ? 8 : cap));
         else it.units = FIELD_UNITS_W'($urandom_range(1, cap));
         r = $urandom_range(0, 99);
         if (r < 5) it.duration = '0;
         else if (r < 80) it.duration = FIELD_DUR_W'($urandom_range(1, 6));
         else if (r < 97) it.duration = FIELD_DUR_W'($urandom_range(7, 30));
         else it.units = FIELD_UNITS_W'(1);   // long job, keep its footprint small
      end
      return it;
   endfunction

   task automatic add_arrival(int unsigned dur, int unsigned units);
      job_item_type it;
      it.kind = frjs_pkg::KIND_ARRIVAL;
      it.duration = FIELD_DUR_W'(dur);
      it.units = FIELD_UNITS_W'(units);
      offered_jobs = {offered_jobs, it};
   endtask

   task automatic add_tick();
      job_item_type it;
      it.kind = frjs_pkg::KIND_TICK;
      it.duration = FIELD_DUR_W'($urandom);
      it.units = FIELD_UNITS_W'($urandom);
      offered_jobs = {offered_jobs, it};
   endtask

   task automatic wait_drained();
      while (offered_jobs.size() != 0 || req_valid || predicted_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_total(logic [FIELD_UNITS_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      units_cfg = (value > SLOT_COUNT) ? SLOT_COUNT : value;
   endtask

   task automatic run_random_phase(logic [FIELD_UNITS_W-1:0] total, bit idle, int count);
      wait_drained();
      write_total(total);
      idling_on = idle;
      repeat (count) offered_jobs = {offered_jobs, random_job()};
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall)
            predicted_reports = {predicted_reports, schedule_step(on_offer)};
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (offered_jobs.size() > 0) begin
               on_offer = offered_jobs.pop_front();
               req_kind <= on_offer.kind;
               req_job_duration <= on_offer.duration;
               req_job_units <= on_offer.units;
               req_valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result backpressure, with one long hold to fill the block up
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 200) begin
         rsp_stall <= 1'b1;
         hold_left <= 300;
         hold_done <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         n = pick_gap();
         rsp_stall <= (n > 0);
         stall_left <= (n > 0) ? n - 1 : 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      sched_report_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_arrived_total, rsp_started_total, rsp_completed_total,
                rsp_busy_units, rsp_busy_sum, rsp_pending_count};
         results_seen <= results_seen + 1;
         if (predicted_reports.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected transaction: status %0d busy %0d pending %0d",
                        got.status, got.busy, got.pending);
         end else begin
            want = predicted_reports.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("report mismatch at %0t", $realtime);
                  $display("  expected st %0d arr %0d start %0d done %0d busy %0d sum %0d pend %0d",
                           want.status, want.arrived, want.started, want.completed,
                           want.busy, want.busy_sum, want.pending);
                  $display("  actual   st %0d arr %0d start %0d done %0d busy %0d sum %0d pend %0d",
                           got.status, got.arrived, got.started, got.completed,
                           got.busy, got.busy_sum, got.pending);
               end
            end
         end
      end
   end

   initial begin
      wait_head = 0;
      wait_tail = 0;
      wait_fill = 0;
      for (int i = 0; i < SLOT_COUNT; i++) run_on[i] = 1'b0;
      units_cfg = SLOT_COUNT;
      arrivals = '0;
      starts = '0;
      finishes = '0;
      load_sum = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: short durations, unit limits, head blocking
      add_arrival(0, 1);
      add_arrival(1, 64);
      add_tick();
      add_tick();
      add_arrival(7, 0);
      add_arrival(7, 65);
      add_arrival(16'hFFFF, 127);
      add_tick();
      add_arrival(16'hFFFF, 1);
      add_arrival(2, 63);
      add_arrival(4, 1);
      add_tick();
      add_arrival(5, 2);
      add_tick();
      add_tick();
      add_arrival(3, 32);
      add_arrival(3, 32);
      repeat (4) add_tick();

      // fill the queue past its depth, back to back
      wait_drained();
      write_total(7'd127);
      idling_on = 1'b0;
      repeat (JOB_QUEUE_DEPTH + 2) add_arrival(3, 1);
      add_arrival(3, 0);
      add_arrival(3, 65);
      repeat (8) add_tick();

      run_random_phase(7'd64, 1'b1, 40);
      run_random_phase(7'd64, 1'b1, 35);
      run_random_phase(7'd7, 1'b1, 35);
      run_random_phase(7'd1, 1'b1, 30);
      run_random_phase(7'd0, 1'b1, 25);
      run_random_phase(7'd100, 1'b0, 35);
      run_random_phase(FIELD_UNITS_W'($urandom_range(1, 64)), 1'b1, 35);
      run_random_phase(FIELD_UNITS_W'($urandom_range(0, 127)), 1'b1, 35);
      run_random_phase(7'd64, 1'b1, 30);

      wait_drained();
      repeat (400) @(posedge clock);
      if (predicted_reports.size() != 0)
         $display("%0d expected transactions never arrived", predicted_reports.size());
      if (error_count == 0 && predicted_reports.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
